[rtl/mlt_pkg.sv]
// Shared types, character codes and token helper functions for the markup
// line tokenizer. No dependencies; every other file but mlt_if.sv uses this package.
`default_nettype none

package mlt_pkg;

   // Bullet indent step
   localparam int unsigned INDENT_STEP = 4;
   // Reciprocal for the bullet level: q = (level * BULLET_RECIP) >> 16.
   // Exact for every 8-bit level and every step from 1 to 8.
   localparam int unsigned BULLET_RECIP = (65536 + INDENT_STEP - 1) / INDENT_STEP;

   // Queue between the front and the back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // Tokens one input item may cause
   localparam int unsigned TOK_SLOTS = 3;
   localparam int unsigned TOK_IDX_W = 2;

   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_BANG   = 8'd33;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_QUOTE1 = 8'd39;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_DASH   = 8'd45;
   localparam logic [7:0] CH_DOT    = 8'd46;
   localparam logic [7:0] CH_GT     = 8'd62;
   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_UNDER  = 8'd95;
   localparam logic [7:0] CH_BTICK  = 8'd96;
   localparam logic [7:0] CH_TILDE  = 8'd126;

   typedef enum logic [2:0] {
      PH_START,
      PH_INDENT,
      PH_LSLASH,
      PH_HASH,
      PH_SKIPWS,
      PH_FENCE,
      PH_BULLET,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      TK_CHAR   = 3'd0,
      TK_BOLD   = 3'd1,
      TK_ITALIC = 3'd2,
      TK_SUB    = 3'd3,
      TK_SUP    = 3'd4,
      TK_CONST  = 3'd5,
      TK_EMPTY  = 3'd6
   } tok_kind_type;

   typedef enum logic [2:0] {
      LK_NORMAL = 3'd0,
      LK_HEADER = 3'd1,
      LK_ESCAPE = 3'd2,
      LK_QUOTE  = 3'd3,
      LK_MONO   = 3'd4,
      LK_BULLET = 3'd5
   } line_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   ch;
      logic         last;
   } tok_type;

   // All tokens of one input item share the line kind and level
   typedef struct packed {
      line_kind_type                lk;
      logic [7:0]                   level;
      logic [TOK_IDX_W-1:0]         cnt;
      tok_type [TOK_SLOTS-1:0]      tok;
   } bundle_type;

   typedef struct packed {
      bundle_type b;
      logic       esc;
      logic       star;
   } work_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {CH_SPACE, [CH_TAB:CH_CR]};
   endfunction

   function automatic logic line_esc(input logic [7:0] c);
      return c inside {CH_UNDER, CH_CARET, CH_STAR, CH_DASH, CH_BSLASH};
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'd255 : s[7:0];
   endfunction

   function automatic work_type push_tok(input work_type w, input tok_kind_type k,
                                         input logic [7:0] ch, input logic last);
      work_type r;
      r = w;
      if (w.b.cnt != TOK_IDX_W'(TOK_SLOTS)) begin
         r.b.tok[w.b.cnt] = '{kind: k, ch: ch, last: last};
         r.b.cnt = w.b.cnt + TOK_IDX_W'(1);
      end
      return r;
   endfunction

   // One byte of line text: escapes, star pairing, emphasis marks
   function automatic work_type body_byte(input work_type w, input logic [7:0] c);
      work_type r;
      logic     done;
      r = w;
      done = 1'b0;
      if (w.esc) begin
         r.esc = 1'b0;
         if (!line_esc(c)) r = push_tok(r, TK_CHAR, CH_BSLASH, 1'b0);
         r = push_tok(r, TK_CHAR, c, 1'b0);
      end else begin
         if (w.star) begin
            r.star = 1'b0;
            if (c == CH_STAR) begin
               r = push_tok(r, TK_BOLD, 8'd0, 1'b0);
               done = 1'b1;
            end else begin
               r = push_tok(r, TK_ITALIC, 8'd0, 1'b0);
            end
         end
         if (!done) begin
            case (c)
               CH_BSLASH: r.esc = 1'b1;
               CH_STAR:   r.star = 1'b1;
               CH_UNDER:  r = push_tok(r, TK_SUB, 8'd0, 1'b0);
               CH_CARET:  r = push_tok(r, TK_SUP, 8'd0, 1'b0);
               CH_BTICK:  r = push_tok(r, TK_CONST, 8'd0, 1'b0);
               default:   r = push_tok(r, TK_CHAR, c, 1'b0);
            endcase
         end
      end
      return r;
   endfunction

   // Tokenize the held prefix bytes as ordinary text
   function automatic work_type replay(input work_type w, input logic [7:0] h0,
                                       input logic [7:0] h1, input logic [1:0] hcnt);
      work_type r;
      r = w;
      if (hcnt != 2'd0) r = body_byte(r, h0);
      if (hcnt == 2'd2) r = body_byte(r, h1);
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/mlt_if.sv]
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
// Depends on nothing; the top level and the front and back modules use them.
`default_nettype none

interface mlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_line;
   modport source (output valid, char_code, end_of_line, input ready);
   modport sink (input valid, char_code, end_of_line, output ready);
endinterface

interface mlt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] token_char;
   logic [2:0] line_kind;
   logic [7:0] line_level;
   logic       last_of_line;
   modport source (output valid, token_kind, token_char, line_kind, line_level,
                   last_of_line, input ready);
   modport sink (input valid, token_kind, token_char, line_kind, line_level,
                 last_of_line, output ready);
endinterface

`default_nettype wire

[rtl/markup_line_tokenizer.sv]
// Markup line tokenizer: bytes pass the bundle queue and the registered result
// stage to rsp_if. One byte is accepted per cycle unless the queue is full; one
// token leaves per cycle while rsp_if is ready. The 4-entry queue absorbs bytes
// whose several tokens hold the result stage. Synchronous active-high reset
// returns the line state to line start and empties the queue and result stage.
`default_nettype none

module markup_line_tokenizer (
   input  wire       clock,
   input  wire       reset,
   mlt_req_if.sink   req_if,
   mlt_rsp_if.source rsp_if
);

   // Front to queue: one bundle per byte that makes any token
   logic                  push;
   mlt_pkg::bundle_type   push_data;

   // Queue to back: head bundle, pop when its last token is taken
   logic                  pop;
   mlt_pkg::bundle_type   head;
   mlt_pkg::q_status_type q_status;

   // Classify each byte against the line prefix state; stall on a full queue
   mlt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Hold bundles so the front keeps taking bytes while tokens wait
   mlt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_status  (q_status),
      .head      (head)
   );

   // Move head-bundle tokens to the output register, one per cycle unless stalled
   mlt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

[rtl/mlt_front.sv]
// Front end: takes bytes, tracks the line prefix state and turns each byte
// into a bundle of up to three tokens. Depends on mlt_pkg and mlt_req_if.
`default_nettype none

module mlt_front (
   input  wire                   clock,
   input  wire                   reset,
   mlt_req_if.sink               req_if,
   input  mlt_pkg::q_status_type q_status,
   output logic                  push,
   output mlt_pkg::bundle_type   push_data
);

   mlt_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]             held0_ff, held0_in;
   logic [7:0]             held1_ff, held1_in;
   logic [1:0]             hcnt_ff, hcnt_in;
   mlt_pkg::line_kind_type kind_ff, kind_in;
   logic [7:0]             level_ff, level_in;
   logic                   star_ff, star_in;
   logic                   esc_ff, esc_in;

   logic                   accept;
   logic [7:0]             c;
   logic [24:0]            bullet_prod;
   mlt_pkg::work_type      w;

   assign req_if.ready = !q_status.full;
   assign accept = req_if.valid && req_if.ready;
   assign c = req_if.char_code;
   assign bullet_prod = {17'd0, level_ff} * 25'(mlt_pkg::BULLET_RECIP);

   always_comb begin
      phase_in = phase_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      hcnt_in = hcnt_ff;
      kind_in = kind_ff;
      level_in = level_ff;
      w = '0;
      w.esc = esc_ff;
      w.star = star_ff;

      if (accept) begin
         if (req_if.end_of_line) begin
            if (phase_ff == mlt_pkg::PH_START) begin
               kind_in = mlt_pkg::LK_NORMAL;
               level_in = 8'd0;
               w = mlt_pkg::push_tok(w, mlt_pkg::TK_EMPTY, 8'd0, 1'b1);
            end else begin
               if (phase_ff == mlt_pkg::PH_LSLASH) begin
                  w = mlt_pkg::push_tok(w, mlt_pkg::TK_CHAR, mlt_pkg::CH_BSLASH, 1'b0);
               end else if (phase_ff == mlt_pkg::PH_FENCE ||
                            phase_ff == mlt_pkg::PH_BULLET) begin
                  kind_in = mlt_pkg::LK_NORMAL;
                  w = mlt_pkg::replay(w, held0_ff, held1_ff, hcnt_ff);
               end
               if (w.esc) w = mlt_pkg::push_tok(w, mlt_pkg::TK_CHAR, mlt_pkg::CH_BSLASH, 1'b0);
               if (w.star) w = mlt_pkg::push_tok(w, mlt_pkg::TK_ITALIC, 8'd0, 1'b0);
               w = mlt_pkg::push_tok(w, mlt_pkg::TK_CHAR, mlt_pkg::CH_LF, 1'b1);
            end
         end else begin
            case (phase_ff)
               mlt_pkg::PH_START, mlt_pkg::PH_INDENT: begin
                  if (mlt_pkg::is_ws(c)) begin
                     level_in = mlt_pkg::sat_add(level_ff, (c == mlt_pkg::CH_TAB) ? 8'd4 : 8'd1);
                     phase_in = mlt_pkg::PH_INDENT;
                  end else begin
                     case (c)
                        mlt_pkg::CH_BSLASH: begin
                           kind_in = mlt_pkg::LK_NORMAL;
                           phase_in = mlt_pkg::PH_LSLASH;
                        end
                        mlt_pkg::CH_HASH: begin
                           kind_in = mlt_pkg::LK_HEADER;
                           level_in = 8'd1;
                           phase_in = mlt_pkg::PH_HASH;
                        end
                        mlt_pkg::CH_BANG: begin
                           kind_in = mlt_pkg::LK_ESCAPE;
                           phase_in = mlt_pkg::PH_BODY;
                        end
                        mlt_pkg::CH_QUOTE1, mlt_pkg::CH_DOT: begin
                           kind_in = mlt_pkg::LK_ESCAPE;
                           phase_in = mlt_pkg::PH_BODY;
                           w = mlt_pkg::body_byte(w, c);
                        end
                        mlt_pkg::CH_GT: begin
                           kind_in = mlt_pkg::LK_QUOTE;
                           phase_in = mlt_pkg::PH_SKIPWS;
                        end
                        mlt_pkg::CH_BTICK, mlt_pkg::CH_TILDE: begin
                           held0_in = c;
                           hcnt_in = 2'd1;
                           phase_in = mlt_pkg::PH_FENCE;
                        end
                        mlt_pkg::CH_STAR, mlt_pkg::CH_DASH: begin
                           held0_in = c;
                           hcnt_in = 2'd1;
                           phase_in = mlt_pkg::PH_BULLET;
                        end
                        default: begin
                           kind_in = mlt_pkg::LK_NORMAL;
                           phase_in = mlt_pkg::PH_BODY;
                           w = mlt_pkg::body_byte(w, c);
                        end
                     endcase
                  end
               end
               mlt_pkg::PH_LSLASH: begin
                  if (!(c == mlt_pkg::CH_HASH || mlt_pkg::line_esc(c)))
                     w = mlt_pkg::push_tok(w, mlt_pkg::TK_CHAR, mlt_pkg::CH_BSLASH, 1'b0);
                  w = mlt_pkg::push_tok(w, mlt_pkg::TK_CHAR, c, 1'b0);
                  phase_in = mlt_pkg::PH_BODY;
               end
               mlt_pkg::PH_HASH: begin
                  if (c == mlt_pkg::CH_HASH) begin
                     level_in = mlt_pkg::sat_add(level_ff, 8'd1);
                  end else if (mlt_pkg::is_ws(c)) begin
                     phase_in = mlt_pkg::PH_SKIPWS;
                  end else begin
                     phase_in = mlt_pkg::PH_BODY;
                     w = mlt_pkg::body_byte(w, c);
                  end
               end
               mlt_pkg::PH_SKIPWS: begin
                  if (!mlt_pkg::is_ws(c)) begin
                     phase_in = mlt_pkg::PH_BODY;
                     w = mlt_pkg::body_byte(w, c);
                  end
               end
               mlt_pkg::PH_FENCE: begin
                  if (c == held0_ff) begin
                     if (hcnt_ff != 2'd2) begin
                        held1_in = c;
                        hcnt_in = 2'd2;
                     end else begin
                        kind_in = mlt_pkg::LK_MONO;
                        hcnt_in = 2'd0;
                        phase_in = mlt_pkg::PH_BODY;
                     end
                  end else begin
                     kind_in = mlt_pkg::LK_NORMAL;
                     hcnt_in = 2'd0;
                     phase_in = mlt_pkg::PH_BODY;
                     w = mlt_pkg::replay(w, held0_ff, held1_ff, hcnt_ff);
                     w = mlt_pkg::body_byte(w, c);
                  end
               end
               mlt_pkg::PH_BULLET: begin
                  if (mlt_pkg::is_ws(c)) begin
                     kind_in = mlt_pkg::LK_BULLET;
                     level_in = bullet_prod[23:16];
                     hcnt_in = 2'd0;
                     phase_in = mlt_pkg::PH_SKIPWS;
                  end else begin
                     kind_in = mlt_pkg::LK_NORMAL;
                     hcnt_in = 2'd0;
                     phase_in = mlt_pkg::PH_BODY;
                     w = mlt_pkg::replay(w, held0_ff, held1_ff, hcnt_ff);
                     w = mlt_pkg::body_byte(w, c);
                  end
               end
               default: begin
                  phase_in = mlt_pkg::PH_BODY;
                  w = mlt_pkg::body_byte(w, c);
               end
            endcase
         end
      end

      // Tokens carry the line kind and level in force when they were made
      w.b.lk = kind_in;
      w.b.level = level_in;
      star_in = w.star;
      esc_in = w.esc;

      // Drop all line state at the end of the line
      if (accept && req_if.end_of_line) begin
         phase_in = mlt_pkg::PH_START;
         held0_in = 8'd0;
         held1_in = 8'd0;
         hcnt_in = 2'd0;
         kind_in = mlt_pkg::LK_NORMAL;
         level_in = 8'd0;
         star_in = 1'b0;
         esc_in = 1'b0;
      end

      push_data = w.b;
      push = accept && (w.b.cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mlt_pkg::PH_START;
         held0_ff <= 8'd0;
         held1_ff <= 8'd0;
         hcnt_ff <= 2'd0;
         kind_ff <= mlt_pkg::LK_NORMAL;
         level_ff <= 8'd0;
         star_ff <= 1'b0;
         esc_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         hcnt_ff <= hcnt_in;
         kind_ff <= kind_in;
         level_ff <= level_in;
         star_ff <= star_in;
         esc_ff <= esc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mlt_queue.sv]
// Short bundle queue between the tokenizer front and back.
// Depends on mlt_pkg for the bundle type and queue depth.
`default_nettype none

module mlt_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  mlt_pkg::bundle_type   push_data,
   input  wire                   pop,
   output mlt_pkg::q_status_type q_status,
   output mlt_pkg::bundle_type   head
);

   mlt_pkg::bundle_type                 slot_ff [mlt_pkg::QDEPTH];
   logic [mlt_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [mlt_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [mlt_pkg::QCNT_W-1:0]          cnt_ff, cnt_in;

   assign q_status.full = (cnt_ff == mlt_pkg::QCNT_W'(mlt_pkg::QDEPTH));
   assign q_status.not_empty = (cnt_ff != '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mlt_pkg::QPTR_W'(mlt_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + mlt_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mlt_pkg::QPTR_W'(mlt_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + mlt_pkg::QPTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + mlt_pkg::QCNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - mlt_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("queue push while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("queue pop while empty");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= mlt_pkg::QCNT_W'(mlt_pkg::QDEPTH))
      else $error("queue count out of range");
   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff - $past(cnt_ff)) == mlt_pkg::QCNT_W'(1))
      else $error("queue count did not follow push");
   a_head_tokens: assert property (@(posedge clock) disable iff (reset)
      q_status.not_empty |-> (head.cnt != '0))
      else $error("queued bundle holds no token");
`endif

endmodule

`default_nettype wire

[rtl/mlt_back.sv]
// Back end: walks head-bundle tokens into the registered result stage,
// one per cycle while it is empty or taken. Depends on mlt_pkg and mlt_rsp_if.
`default_nettype none

module mlt_back (
   input  wire                   clock,
   input  wire                   reset,
   input  mlt_pkg::q_status_type q_status,
   input  mlt_pkg::bundle_type   head,
   output logic                  pop,
   mlt_rsp_if.source             rsp_if
);

   logic [mlt_pkg::TOK_IDX_W-1:0] idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   mlt_pkg::tok_type              tok_ff;
   mlt_pkg::line_kind_type        lk_ff;
   logic [7:0]                    level_ff;
   logic                          load;
   logic                          take;
   logic                          last_tok;

   assign load = !valid_ff || rsp_if.ready;
   assign take = load && q_status.not_empty;
   assign last_tok = (idx_ff == head.cnt - mlt_pkg::TOK_IDX_W'(1));

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      pop = 1'b0;
      if (load) valid_in = q_status.not_empty;
      if (take) begin
         if (last_tok) begin
            pop = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + mlt_pkg::TOK_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff <= head.tok[idx_ff];
         lk_ff <= head.lk;
         level_ff <= head.level;
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.token_kind = tok_ff.kind;
   assign rsp_if.token_char = tok_ff.ch;
   assign rsp_if.line_kind = lk_ff;
   assign rsp_if.line_level = level_ff;
   assign rsp_if.last_of_line = tok_ff.last;

endmodule

`default_nettype wire

[dv/markup_line_tokenizer_tb.sv]
// Self-checking testbench for markup_line_tokenizer: directed lines, then random lines.
// Predicts every token in its own line scanner and checks the rsp channel in order.
// Depends on rtl/mlt_pkg.sv, rtl/mlt_if.sv and rtl/markup_line_tokenizer.sv.

module markup_line_tokenizer_tb;
   import mlt_pkg::*;

   localparam int unsigned CLK_HALF     = 5;
   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned IDLE_PCT     = 37;
   localparam int unsigned RANDOM_ITEMS = 230;
   localparam int unsigned CALM_ITEMS   = 120;  // items sent with neither side idling
   localparam int unsigned PRESSURE_AT  = 60;   // tokens seen before the long hold-off
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned MAX_TOKENS   = 5;    // cap on tokens predicted per item
   localparam int unsigned TAB_WIDTH    = 4;
   localparam int unsigned NUM_DIRECTED = 30;

   // One token as seen on the rsp channel
   typedef struct packed {
      tok_kind_type  kind;
      logic [7:0]    ch;
      line_kind_type lk;
      logic [7:0]    level;
      logic          last;
   } line_token_t;

   // One req item; typed rows carry the single token they must produce
   typedef struct packed {
      logic [7:0]  code;
      logic        eol;
      logic        typed;
      line_token_t want;
   } stim_row_t;

   localparam line_token_t NO_WANT = '{TK_CHAR, 8'd0, LK_NORMAL, 8'd0, 1'b0};

   localparam logic [7:0] MARKUP_CHARS [10] = '{CH_STAR, CH_UNDER, CH_CARET, CH_BTICK,
      CH_BSLASH, CH_HASH, CH_DASH, CH_TILDE, CH_SPACE, CH_TAB};

   // Directed lines. Rows whose token is obvious carry it; the rest go to the predictor.
   stim_row_t directed_rows [NUM_DIRECTED] = '{
      // empty line right after reset
      '{8'hA5,     1'b1, 1'b1, '{TK_EMPTY,  8'd0,   LK_NORMAL, 8'd0, 1'b1}},
      // zero byte and all-ones byte as plain text
      '{8'h00,     1'b0, 1'b1, '{TK_CHAR,   8'h00,  LK_NORMAL, 8'd0, 1'b0}},
      '{8'hFF,     1'b0, 1'b1, '{TK_CHAR,   8'hFF,  LK_NORMAL, 8'd0, 1'b0}},
      '{8'h5A,     1'b1, 1'b1, '{TK_CHAR,   CH_LF,  LK_NORMAL, 8'd0, 1'b1}},
      // whitespace-only line keeps its indent
      '{CH_SPACE,  1'b0, 1'b0, NO_WANT},
      '{8'hFF,     1'b1, 1'b1, '{TK_CHAR,   CH_LF,  LK_NORMAL, 8'd1, 1'b1}},
      // indented level-2 header with every emphasis mark, escape and a closing star
      '{CH_TAB,    1'b0, 1'b0, NO_WANT},
      '{CH_HASH,   1'b0, 1'b0, NO_WANT},
      '{CH_HASH,   1'b0, 1'b0, NO_WANT},
      '{CH_SPACE,  1'b0, 1'b0, NO_WANT},
      '{CH_STAR,   1'b0, 1'b0, NO_WANT},
      '{CH_STAR,   1'b0, 1'b1, '{TK_BOLD,   8'd0,   LK_HEADER, 8'd2, 1'b0}},
      '{CH_UNDER,  1'b0, 1'b1, '{TK_SUB,    8'd0,   LK_HEADER, 8'd2, 1'b0}},
      '{CH_CARET,  1'b0, 1'b1, '{TK_SUP,    8'd0,   LK_HEADER, 8'd2, 1'b0}},
      '{CH_BTICK,  1'b0, 1'b1, '{TK_CONST,  8'd0,   LK_HEADER, 8'd2, 1'b0}},
      '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{8'h61,     1'b0, 1'b0, NO_WANT},
      '{CH_STAR,   1'b0, 1'b0, NO_WANT},
      '{8'h00,     1'b1, 1'b0, NO_WANT},
      // bullet one step in, ending on a dangling backslash
      '{CH_TAB,    1'b0, 1'b0, NO_WANT},
      '{CH_DASH,   1'b0, 1'b0, NO_WANT},
      '{CH_SPACE,  1'b0, 1'b0, NO_WANT},
      '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{8'h3C,     1'b1, 1'b0, NO_WANT},
      // fence cut short after two marks
      '{CH_BTICK,  1'b0, 1'b0, NO_WANT},
      '{CH_BTICK,  1'b0, 1'b0, NO_WANT},
      '{8'h78,     1'b0, 1'b0, NO_WANT},
      '{8'hC3,     1'b1, 1'b1, '{TK_CHAR,   CH_LF,  LK_NORMAL, 8'd0, 1'b1}},
      // backslash alone at line start
      '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{8'h81,     1'b1, 1'b0, NO_WANT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlt_req_if req_ch ();
   mlt_rsp_if rsp_ch ();

   markup_line_tokenizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   stim_row_t   byte_stream [$];
   line_token_t expected_tokens [$];
   int unsigned tokens_seen    = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   logic        calm           = 1'b0;

   // ---------------------------------------------------------------------------------
   // Line scanner: tracks the prefix phase, held fence/bullet marks, pending star and
   // pending backslash, and appends every token the block must send.
   // ---------------------------------------------------------------------------------
   phase_type     scan_phase;
   logic [7:0]    held_mark [2];
   int unsigned   held_count;
   line_kind_type cur_line_kind;
   logic [7:0]    cur_level;
   logic          star_pending;
   logic          escape_pending;
   int unsigned   step_tokens;

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Marks that a backslash escapes without showing itself
   function automatic logic drops_backslash(logic [7:0] c);
      return c == CH_UNDER || c == CH_CARET || c == CH_STAR || c == CH_DASH ||
             c == CH_BSLASH;
   endfunction

   function automatic logic [7:0] add_capped(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic void reset_line();
      scan_phase     = PH_START;
      held_mark[0]   = 8'd0;
      held_mark[1]   = 8'd0;
      held_count     = 0;
      cur_line_kind  = LK_NORMAL;
      cur_level      = 8'd0;
      star_pending   = 1'b0;
      escape_pending = 1'b0;
   endfunction

   // Tokens carry the line kind and level in force at the moment they are made
   function automatic void put_token(tok_kind_type kind, logic [7:0] ch, logic last);
      if (step_tokens < MAX_TOKENS) begin
         expected_tokens.push_back('{kind, ch, cur_line_kind, cur_level, last});
         step_tokens++;
      end
   endfunction

   function automatic void text_byte(logic [7:0] c);
      if (escape_pending) begin
         escape_pending = 1'b0;
         if (!drops_backslash(c)) put_token(TK_CHAR, CH_BSLASH, 1'b0);
         put_token(TK_CHAR, c, 1'b0);
         return;
      end
      if (star_pending) begin
         star_pending = 1'b0;
         if (c == CH_STAR) begin
            put_token(TK_BOLD, 8'd0, 1'b0);
            return;
         end
         put_token(TK_ITALIC, 8'd0, 1'b0);
      end
      case (c)
         CH_BSLASH: escape_pending = 1'b1;
         CH_STAR:   star_pending = 1'b1;
         CH_UNDER:  put_token(TK_SUB, 8'd0, 1'b0);
         CH_CARET:  put_token(TK_SUP, 8'd0, 1'b0);
         CH_BTICK:  put_token(TK_CONST, 8'd0, 1'b0);
         default:   put_token(TK_CHAR, c, 1'b0);
      endcase
   endfunction

   // A prefix that did not complete turns the line normal; its marks become text
   function automatic void replay_prefix();
      int unsigned cnt;
      int unsigned i;
      cnt = held_count;
      cur_line_kind = LK_NORMAL;
      scan_phase = PH_BODY;
      held_count = 0;
      for (i = 0; i < cnt; i++) text_byte(held_mark[i]);
   endfunction

   // First byte past the indent picks the line kind
   function automatic void lead_byte(logic [7:0] c);
      case (c)
         CH_BSLASH: begin
            cur_line_kind = LK_NORMAL;
            scan_phase = PH_LSLASH;
         end
         CH_HASH: begin
            cur_line_kind = LK_HEADER;
            cur_level = 8'd1;
            scan_phase = PH_HASH;
         end
         CH_BANG: begin
            cur_line_kind = LK_ESCAPE;
            scan_phase = PH_BODY;
         end
         CH_QUOTE1, CH_DOT: begin
            cur_line_kind = LK_ESCAPE;
            scan_phase = PH_BODY;
            text_byte(c);
         end
         CH_GT: begin
            cur_line_kind = LK_QUOTE;
            scan_phase = PH_SKIPWS;
         end
         CH_BTICK, CH_TILDE: begin
            held_mark[0] = c;
            held_count = 1;
            scan_phase = PH_FENCE;
         end
         CH_STAR, CH_DASH: begin
            held_mark[0] = c;
            held_count = 1;
            scan_phase = PH_BULLET;
         end
         default: begin
            cur_line_kind = LK_NORMAL;
            scan_phase = PH_BODY;
            text_byte(c);
         end
      endcase
   endfunction

   function automatic void close_line();
      case (scan_phase)
         PH_START: begin
            cur_line_kind = LK_NORMAL;
            cur_level = 8'd0;
            put_token(TK_EMPTY, 8'd0, 1'b1);
            reset_line();
            return;
         end
         PH_LSLASH:          put_token(TK_CHAR, CH_BSLASH, 1'b0);
         PH_FENCE, PH_BULLET: replay_prefix();
         default: ;
      endcase
      if (escape_pending) put_token(TK_CHAR, CH_BSLASH, 1'b0);
      if (star_pending) put_token(TK_ITALIC, 8'd0, 1'b0);
      put_token(TK_CHAR, CH_LF, 1'b1);
      reset_line();
   endfunction

   function automatic void tokenize_item(logic [7:0] c, logic eol);
      step_tokens = 0;
      if (eol) begin
         close_line();
         return;
      end
      case (scan_phase)
         PH_START, PH_INDENT: begin
            if (is_blank(c)) begin
               cur_level = add_capped(cur_level, (c == CH_TAB) ? 8'(TAB_WIDTH) : 8'd1);
               scan_phase = PH_INDENT;
            end else begin
               lead_byte(c);
            end
         end
         PH_LSLASH: begin
            if (!(c == CH_HASH || drops_backslash(c))) put_token(TK_CHAR, CH_BSLASH, 1'b0);
            put_token(TK_CHAR, c, 1'b0);
            scan_phase = PH_BODY;
         end
         PH_HASH: begin
            if (c == CH_HASH) begin
               cur_level = add_capped(cur_level, 8'd1);
            end else if (is_blank(c)) begin
               scan_phase = PH_SKIPWS;
            end else begin
               scan_phase = PH_BODY;
               text_byte(c);
            end
         end
         PH_SKIPWS: begin
            if (!is_blank(c)) begin
               scan_phase = PH_BODY;
               text_byte(c);
            end
         end
         PH_FENCE: begin
            if (c == held_mark[0]) begin
               if (held_count < 2) begin
                  held_mark[1] = c;
                  held_count = 2;
               end else begin
                  cur_line_kind = LK_MONO;
                  held_count = 0;
                  scan_phase = PH_BODY;
               end
            end else begin
               replay_prefix();
               text_byte(c);
            end
         end
         PH_BULLET: begin
            if (is_blank(c)) begin
               cur_line_kind = LK_BULLET;
               cur_level = 8'(cur_level / INDENT_STEP);
               held_count = 0;
               scan_phase = PH_SKIPWS;
            end else begin
               replay_prefix();
               text_byte(c);
            end
         end
         default: begin
            scan_phase = PH_BODY;
            text_byte(c);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------------
   function automatic void add_item(logic [7:0] code, logic eol);
      byte_stream.push_back('{code, eol, 1'b0, NO_WANT});
   endfunction

   function automatic logic [7:0] pick_blank();
      if ($urandom_range(0, 2) == 0) return CH_TAB;
      return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
   endfunction

   // Lean on markup characters so emphasis and escapes are hit often
   function automatic logic [7:0] pick_text();
      if ($urandom_range(0, 9) < 5) return MARKUP_CHARS[$urandom_range(0, 9)];
      return 8'($urandom);
   endfunction

   // Mostly well-formed prefixes with random text, some cut short, some pure noise
   function automatic void add_random_line();
      int unsigned choice;
      logic [7:0]  mark;
      if ($urandom_range(0, 9) >= 6) repeat ($urandom_range(1, 3)) add_item(pick_blank(), 1'b0);
      choice = $urandom_range(0, 9);
      case (choice)
         0: ;
         1: begin
            repeat ($urandom_range(1, 3)) add_item(CH_HASH, 1'b0);
            if ($urandom_range(0, 1)) add_item(pick_blank(), 1'b0);
         end
         2: add_item(CH_BANG, 1'b0);
         3: add_item($urandom_range(0, 1) ? CH_QUOTE1 : CH_DOT, 1'b0);
         4: begin
            add_item(CH_GT, 1'b0);
            if ($urandom_range(0, 1)) add_item(pick_blank(), 1'b0);
         end
         5: begin
            mark = $urandom_range(0, 1) ? CH_BTICK : CH_TILDE;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3)
               add_item(mark, 1'b0);
         end
         6: begin
            add_item($urandom_range(0, 1) ? CH_STAR : CH_DASH, 1'b0);
            if ($urandom_range(0, 3) != 0) add_item(pick_blank(), 1'b0);
         end
         7: begin
            add_item(CH_BSLASH, 1'b0);
            if ($urandom_range(0, 4) != 0)
               add_item($urandom_range(0, 1) ? CH_HASH : pick_text(), 1'b0);
         end
         8: repeat ($urandom_range(1, 6)) add_item(8'($urandom), 1'b0);
         default: begin
            // empty or whitespace-only line
            add_item(8'($urandom), 1'b1);
            return;
         end
      endcase
      repeat ($urandom_range(0, 8)) add_item(pick_text(), 1'b0);
      add_item(8'($urandom), 1'b1);
   endfunction

   // ---------------------------------------------------------------------------------
   // Token checker
   // ---------------------------------------------------------------------------------
   function automatic void check_token();
      line_token_t want;
      line_token_t got;
      got = '{tok_kind_type'(rsp_ch.token_kind), rsp_ch.token_char,
              line_kind_type'(rsp_ch.line_kind), rsp_ch.line_level, rsp_ch.last_of_line};
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("token %0d: unexpected, kind %0d char %02h line %0d level %0d last %0b",
                     tokens_seen, got.kind, got.ch, got.lk, got.level, got.last);
         return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch || got.lk !== want.lk ||
          got.level !== want.level || got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display({"token %0d: expected kind %0d char %02h line %0d level %0d last %0b,",
                      " got kind %0d char %02h line %0d level %0d last %0b"},
                     tokens_seen, want.kind, want.ch, want.lk, want.level, want.last,
                     got.kind, got.ch, got.lk, got.level, got.last);
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Token sink: random ready, one long hold-off to fill the block, calm stretch
   // ---------------------------------------------------------------------------------
   initial begin : token_sink
      int unsigned hold_left;
      logic        pressure_done;
      hold_left = 0;
      pressure_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) check_token();
            if (hold_left != 0) begin
               hold_left--;
               rsp_ch.ready <= 1'b0;
            end else if (!pressure_done && tokens_seen >= PRESSURE_AT) begin
               // hold off long enough for the queue to fill and req to stall
               pressure_done = 1'b1;
               hold_left = HOLD_CYCLES;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
         end
      end
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence: build stimulus, reset, send every item, drain, report
   // ---------------------------------------------------------------------------------
   initial begin : byte_source
      int unsigned idx;
      int unsigned mark;
      int unsigned random_start;
      int unsigned calm_from;

      req_ch.valid       <= 1'b0;
      req_ch.char_code   <= 8'd0;
      req_ch.end_of_line <= 1'b0;
      reset_line();

      foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);

      // Saturating line: indent past 255 into a bullet
      repeat (66) add_item(CH_TAB, 1'b0);
      add_item(CH_STAR, 1'b0);
      add_item(CH_SPACE, 1'b0);
      repeat ($urandom_range(1, 4)) add_item(pick_text(), 1'b0);
      add_item(8'($urandom), 1'b1);

      random_start = byte_stream.size();
      while (byte_stream.size() - random_start < RANDOM_ITEMS) add_random_line();
      calm_from = random_start + 100;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (idx = 0; idx < byte_stream.size(); idx++) begin
         calm = (idx >= calm_from) && (idx < calm_from + CALM_ITEMS);
         while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid       <= 1'b1;
         req_ch.char_code   <= byte_stream[idx].code;
         req_ch.end_of_line <= byte_stream[idx].eol;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);

         // Item accepted at this edge: predict its tokens
         mark = expected_tokens.size();
         tokenize_item(byte_stream[idx].code, byte_stream[idx].eol);
         if (byte_stream[idx].typed) begin
            // typed rows state their token outright; drop the predicted copy
            while (expected_tokens.size() > mark) void'(expected_tokens.pop_back());
            expected_tokens.push_back(byte_stream[idx].want);
         end
      end
      req_ch.valid <= 1'b0;
      calm = 1'b0;

      // Wait out outstanding tokens, then watch for strays
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
